@@ design/crc32_msb_first_remainder_defines.svh @@
// Assertion helpers shared by the CRC block.
`ifndef CRC32_MSB_FIRST_REMAINDER_DEFINES_SVH
`define CRC32_MSB_FIRST_REMAINDER_DEFINES_SVH

// Same-cycle implication.
`define CRC32M_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CRC32M_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/crc32m_pkg.sv @@
package crc32m_pkg;

   localparam int CRC_BYTES_DEFAULT = 4;
   localparam logic [31:0] POLY_RESET = 32'h04C11DB7;
   localparam int CSR_ADDR_BITS = 3;

   // Register index as decoded from the word address bit.
   localparam logic REG_POLYNOMIAL = 1'b0;

   typedef enum logic {
      CMD_DATA   = 1'b0,
      CMD_FINISH = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
   } beat_type;

   typedef struct packed {
      logic s1_valid;
      logic s1_finish;
      logic advance;
   } status_type;

endpackage

@@ design/crc32m_csr.sv @@
module crc32m_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crc32m_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output logic [31:0]                         poly
);
   import crc32m_pkg::*;

   logic [31:0] poly_ff;
   logic        reg_idx;
   logic        wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_idx == REG_POLYNOMIAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
      end else if (wr_en) begin
         poly_ff <= csr_pwdata;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_POLYNOMIAL: csr_prdata = poly_ff;
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign poly = poly_ff;

endmodule

@@ design/crc32m_core.sv @@
module crc32m_core #(
   parameter int CRC_BYTES = crc32m_pkg::CRC_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            poly,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  crc32m_pkg::cmd_type    req_cmd,
   input  logic [7:0]             req_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_crc,
   output logic [31:0]            rsp_count,
   output crc32m_pkg::status_type status
);
   import crc32m_pkg::*;

   localparam int RemBits = 8 * CRC_BYTES;

   beat_type           s1_beat_ff;
   logic               s1_valid_ff;
   logic               advance;
   logic               s1_finish;

   logic [RemBits-1:0] crc_ff;
   logic [RemBits-1:0] crc_in;
   logic [31:0]        count_ff;
   logic [31:0]        count_in;
   logic [RemBits-1:0] poly_aligned;
   logic [31:0]        crc_low;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_crc_ff;
   logic [31:0]        rsp_count_ff;

   // Polynomial register is MSB aligned to the remainder width.
   generate
      if (RemBits > 32) begin : g_poly_wide
         assign poly_aligned = {poly, {(RemBits-32){1'b0}}};
      end else begin : g_poly_narrow
         assign poly_aligned = poly[31 -: RemBits];
      end
      if (RemBits >= 32) begin : g_out_wide
         assign crc_low = crc_ff[31:0];
      end else begin : g_out_narrow
         assign crc_low = {{(32-RemBits){1'b0}}, crc_ff};
      end
   endgenerate

   assign s1_finish  = (s1_beat_ff.cmd == CMD_FINISH);
   // A held result blocks only a finish beat.
   assign advance    = s1_valid_ff && (!s1_finish || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   // Remainder kept in direct (non-augmented) form: feedback is the top bit
   // xor the incoming bit, so finish needs no trailing zero shifts.
   always_comb begin
      logic [RemBits-1:0] work;
      logic [7:0]         bits;
      logic               fb;
      work = crc_ff;
      bits = s1_beat_ff.data;
      for (int k = 0; k < 8; k++) begin
         fb   = work[RemBits-1] ^ bits[7];
         work = (work << 1) ^ ({RemBits{fb}} & poly_aligned);
         bits = bits << 1;
      end
      crc_in = work;
   end

   assign count_in = (count_ff == 32'hFFFF_FFFF) ? count_ff : count_ff + 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_beat_ff.cmd  <= req_cmd;
         s1_beat_ff.data <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= '0;
         count_ff <= '0;
      end else if (advance) begin
         case (s1_beat_ff.cmd)
            CMD_DATA: begin
               crc_ff   <= crc_in;
               count_ff <= count_in;
            end
            default: begin
               crc_ff   <= '0;
               count_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && s1_finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_finish) begin
         rsp_crc_ff   <= crc_low;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_crc    = rsp_crc_ff;
   assign rsp_count  = rsp_count_ff;

   assign status.s1_valid  = s1_valid_ff;
   assign status.s1_finish = s1_finish;
   assign status.advance   = advance;

endmodule

@@ design/crc32_msb_first_remainder.sv @@
// Channel | Dir | Ports                               | Contents
// req     | in  | req_tvalid/tready/tdata/tuser       | data byte; command
// rsp     | out | rsp_tvalid/tready/tdata            | crc value, byte count
// csr     | in  | csr_psel/penable/pwrite/paddr/...   | polynomial at 0x0
//
// One beat per cycle unless a held result stalls a finish beat: eight bit steps of the
// remainder update run combinationally between the input stage and the state/result registers.
// A finish beat passes the input stage and then loads the result register, held until taken.
// Reset (synchronous) clears remainder, byte count and valids; polynomial = 0x04C11DB7.
// A result waiting on rsp_tready stalls only a following finish beat.
`include "crc32_msb_first_remainder_defines.svh"

module crc32_msb_first_remainder #(
   parameter int CRC_BYTES = crc32m_pkg::CRC_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] data_byte
   input  logic [0:0]                          req_tuser,   // [0] command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [63:0]                         rsp_tdata,   // [31:0] crc_value, [63:32] byte_count
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crc32m_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import crc32m_pkg::*;

   logic [31:0] poly;
   logic [31:0] rsp_crc;
   logic [31:0] rsp_count;
   status_type  status;
   cmd_type     req_cmd;

   assign req_cmd = cmd_type'(req_tuser[0]);

   crc32m_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .poly        (poly)
   );

   crc32m_core #(
      .CRC_BYTES (CRC_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .poly       (poly),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_cmd),
      .req_data   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_crc    (rsp_crc),
      .rsp_count  (rsp_count),
      .status     (status)
   );

   assign rsp_tdata = {rsp_count, rsp_crc};

   `CRC32M_ASSERT_NEXT(a_finish_loads_result, clock, reset, status.advance && status.s1_finish, rsp_tvalid, "finish beat did not load a result")
   `CRC32M_ASSERT_NOW(a_ready_when_empty, clock, reset, !status.s1_valid, req_tready, "input stage empty but not ready")
   `CRC32M_ASSERT_NEXT(a_no_spurious_result, clock, reset, !rsp_tvalid && !(status.advance && status.s1_finish), !rsp_tvalid, "result valid without finish beat")

endmodule

@@ tb/tb_crc32_msb_first_remainder.sv @@
module tb_crc32_msb_first_remainder;
   timeunit 1ns;
   timeprecision 1ps;

   import crc32m_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] POLY_ADDR = {REG_POLYNOMIAL, 2'b00};
   localparam int RANDOM_BEATS = 1450;
   localparam int NUM_SETTINGS = 8;

   typedef struct packed {
      logic [31:0] byte_count;
      logic [31:0] crc_value;
   } crc_result_type;

   // Running CRC of the current message, plus the results still owed by the block.
   class crc_tracker;
      logic [31:0]    poly;
      logic [31:0]    rem;
      logic [31:0]    nbytes;
      crc_result_type pending_crcs[$];
      int             errors;
      int             crcs_checked;

      function new();
         poly = POLY_RESET;
         rem = '0;
         nbytes = '0;
         errors = 0;
         crcs_checked = 0;
      endfunction

      function void shift_in(logic b);
         logic top;
         top = rem[31];
         rem = {rem[30:0], b};
         if (top) begin
            rem = rem ^ poly;
         end
      endfunction

      function void absorb_beat(cmd_type cmd, logic [7:0] data);
         crc_result_type res;
         if (cmd == CMD_DATA) begin
            for (int k = 7; k >= 0; k--) begin
               shift_in(data[k]);
            end
            if (nbytes != 32'hFFFF_FFFF) begin
               nbytes = nbytes + 1;
            end
         end else begin
            // augmentation: 32 zero bits flush the message through the divider
            repeat (32) shift_in(1'b0);
            res.crc_value = rem;
            res.byte_count = nbytes;
            pending_crcs.push_back(res);
            rem = '0;
            nbytes = '0;
         end
      endfunction

      function void check_crc(logic [63:0] tdata);
         crc_result_type want;
         crc_result_type got;
         got = tdata;
         if (pending_crcs.size() == 0) begin
            $display("%0t: unexpected result beat crc=%08h count=%0d",
                     $time, got.crc_value, got.byte_count);
            errors++;
         end else begin
            want = pending_crcs.pop_front();
            crcs_checked++;
            if (got.crc_value !== want.crc_value) begin
               $display("%0t: crc_value mismatch: expected %08h actual %08h",
                        $time, want.crc_value, got.crc_value);
               errors++;
            end
            if (got.byte_count !== want.byte_count) begin
               $display("%0t: byte_count mismatch: expected %0d actual %0d",
                        $time, want.byte_count, got.byte_count);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   crc_tracker tracker = new();
   bit         no_idle;
   int         beats_sent;
   int         settings_used;

   crc32_msb_first_remainder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // mostly short gaps, a few long ones, none while no_idle is set
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // sampled in the active region of the rising edge, i.e. pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.absorb_beat(cmd_type'(req_tuser[0]), req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_crc(rsp_tdata);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == POLY_ADDR) begin
            tracker.poly = csr_pwdata;
         end
      end
   end

   // result side back-pressure
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   // called at a falling edge; returns at the falling edge after the accept
   task automatic send_beat(cmd_type cmd, logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = data;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++) begin
         send_beat(CMD_DATA, 8'($urandom_range(0, 255)));
      end
      send_beat(CMD_FINISH, 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (tracker.pending_crcs.size() != 0) @(posedge clock);
      // result path is the input stage and the result register; pad the wait as well
      repeat (6) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [31:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = POLY_ADDR;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic csr_check();
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = POLY_ADDR;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== tracker.poly) begin
         $display("%0t: polynomial readback mismatch: expected %08h actual %08h",
                  $time, tracker.poly, csr_prdata);
         tracker.errors++;
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic directed_beats();
      byte unsigned check_str[9] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
                                     8'h36, 8'h37, 8'h38, 8'h39};
      // empty message, with a nonzero byte riding on the finish
      send_beat(CMD_FINISH, 8'hFF);
      send_beat(CMD_DATA, 8'h00);
      send_beat(CMD_FINISH, 8'h00);
      send_beat(CMD_DATA, 8'hFF);
      send_beat(CMD_FINISH, 8'h5A);
      send_beat(CMD_DATA, 8'h80);
      send_beat(CMD_DATA, 8'h01);
      send_beat(CMD_FINISH, 8'h00);
      foreach (check_str[i]) begin
         send_beat(CMD_DATA, check_str[i]);
      end
      send_beat(CMD_FINISH, 8'h00);
      // finishes back to back
      send_beat(CMD_FINISH, 8'h00);
      send_beat(CMD_FINISH, 8'hA5);
      send_beat(CMD_DATA, 8'h55);
      send_beat(CMD_DATA, 8'hAA);
      send_beat(CMD_FINISH, 8'hFF);
   endtask

   task automatic random_phase(int budget);
      int start;
      int len;
      start = beats_sent;
      while (beats_sent - start < budget) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(13, 64);
         end else begin
            len = $urandom_range(0, 12);
         end
         send_message(len);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      logic [31:0] polys[NUM_SETTINGS];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      no_idle = 1'b0;
      beats_sent = 0;
      settings_used = 1;
      polys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                32'h0, 32'h0, 32'h0, POLY_RESET};
      polys[4] = $urandom();
      polys[5] = $urandom();
      polys[6] = $urandom();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset value of the polynomial first
      csr_check();
      directed_beats();
      random_phase(RANDOM_BEATS / (NUM_SETTINGS + 1));
      foreach (polys[i]) begin
         wait_drained();
         csr_write(polys[i]);
         csr_check();
         settings_used++;
         if (i == 1 || i == 3) begin
            directed_beats();
         end
         random_phase(RANDOM_BEATS / (NUM_SETTINGS + 1));
      end
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Sent %0d beats, checked %0d CRC results over %0d polynomial settings",
               beats_sent, tracker.crcs_checked, settings_used);
      if (tracker.errors == 0 && tracker.pending_crcs.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         if (tracker.pending_crcs.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, tracker.pending_crcs.size());
         end
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/crc32m_pkg.sv
design/crc32m_csr.sv
design/crc32m_core.sv
design/crc32_msb_first_remainder.sv
tb/tb_crc32_msb_first_remainder.sv
